// File: sv/wstd_pkg.sv
// ----------------------------------------------------------------------------
// wstd_pkg: shared types and constants of the work-stealing task dispatcher
// Command codes, fetch source codes, register map and the front/back word.
// ----------------------------------------------------------------------------
package wstd_pkg;

  typedef enum logic [1:0] {
    CMD_SUBMIT  = 2'd0,
    CMD_FETCH   = 2'd1,
    CMD_DISCARD = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_OWN    = 2'd1,
    SRC_INJECT = 2'd2,
    SRC_STOLEN = 2'd3
  } src_t;

  localparam int TASK_W = 16;
  localparam int WID_W  = 3;
  localparam int TICK_W = 16;

  // register byte addresses
  localparam logic [2:0] ADDR_ACTIVE = 3'd0;
  localparam logic [2:0] ADDR_STOP   = 3'd4;

  // back-end execution states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DONE
  } bstate_t;

  // one classified command, front to back
  typedef struct packed {
    cmd_t              cmd;
    logic              from_worker;
    logic [WID_W-1:0]  wid;
    logic [TASK_W-1:0] task_id;
    logic              in_range;
  } word_t;

endpackage

// File: sv/wstd_front.sv
// ----------------------------------------------------------------------------
// wstd_front: command intake
// Registers an accepted command, checks the worker range and holds it in a
// one-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
module wstd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [1:0]                 cmd,
  input  logic                       from_worker,
  input  logic [2:0]                 worker_id,
  input  logic [15:0]                task_in,
  input  logic [3:0]                 span,
  output logic                       q_valid,
  output wstd_pkg::word_t            q_word,
  input  logic                       q_pop
);

  logic in_range;

  // worker must be below the active span
  assign in_range = ({1'b0, worker_id} < span);

  // one-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take) begin
      q_valid <= 1'b1;
    end else if (q_pop) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_word.cmd         <= wstd_pkg::cmd_t'(cmd);
      q_word.from_worker <= from_worker;
      q_word.wid         <= worker_id;
      q_word.task_id     <= task_in;
      q_word.in_range    <= in_range;
    end
  end

endmodule

// File: sv/wstd_back.sv
// ----------------------------------------------------------------------------
// wstd_back: store engine
// Keeps deque and FIFO pointers, picks the source of a fetch, and does the
// memory access for submits and pops.
// ----------------------------------------------------------------------------
module wstd_back #(
  parameter int MAX_WORKERS   = 8,
  parameter int LOCAL_DEPTH   = 16,
  parameter int INJECT_DEPTH  = 64,
  parameter int POLL_INTERVAL = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  wstd_pkg::word_t       q_word,
  output logic                  q_pop,
  input  logic [3:0]            span,
  input  logic                  stopping,
  output logic                  strobe,
  output logic                  accepted,
  output logic                  found,
  output logic [15:0]           task_out,
  output logic [1:0]            source,
  output logic [2:0]            victim
);

  localparam int LW  = (LOCAL_DEPTH > 1) ? $clog2(LOCAL_DEPTH) : 1;
  localparam int IW  = (INJECT_DEPTH > 1) ? $clog2(INJECT_DEPTH) : 1;
  localparam int WW  = 3;
  localparam int NW  = (MAX_WORKERS < 8) ? MAX_WORKERS : 8;
  localparam int MW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int DA  = WW + LW;
  localparam int PW  = (POLL_INTERVAL > 1) ? $clog2(POLL_INTERVAL) : 1;

  wstd_pkg::bstate_t state, state_next;

  logic [LW-1:0] dtop  [NW];
  logic [LW:0]   dcnt  [NW];
  logic [wstd_pkg::TICK_W-1:0] tick [NW];
  logic [PW-1:0] phase [NW];
  logic [IW-1:0] ihead;
  logic [IW:0]   icnt;

  logic [15:0] dmem [2**DA];
  logic [15:0] imem [INJECT_DEPTH];

  // decision for the current word
  logic          poll;
  logic [2:0]    w;
  logic          own_ne, inj_ne;
  logic [NW-1:0] ne;
  logic          steal_ok;
  logic [2:0]    vic;
  logic [1:0]    src;
  logic          sub_ok;
  logic [LW:0]   own_sum, push_sum;
  logic [LW-1:0] own_pos, push_pos, top_v;
  logic [IW:0]   inj_sum;
  logic [IW-1:0] ipos;
  logic          rd_deq;
  logic [DA-1:0] rd_addr;
  logic          res_acc;
  logic [1:0]    res_src;
  logic [2:0]    res_vic;
  logic          res_deq;
  logic [15:0]   drd, ird;

  assign w = q_word.wid;

  // phase counts fetches modulo the poll interval, back to zero when tick wraps
  always_comb begin
    for (int i = 0; i < NW; i++) ne[i] = (dcnt[i] != '0) && (i < span);
    own_ne = (dcnt[w[MW-1:0]] != '0);
    inj_ne = (icnt != '0);
    poll   = (phase[w[MW-1:0]] == '0);
  end

  // victim: first non-empty deque after w, cyclic over the span
  always_comb begin
    logic [3:0] v;
    steal_ok = 1'b0;
    vic      = '0;
    for (int off = 7; off >= 1; off--) begin
      v = {1'b0, w} + 4'(off);
      if (v >= span) v = v - span;
      if (off < span && ne[v[2:0]]) begin
        steal_ok = 1'b1;
        vic      = v[2:0];
      end
    end
  end

  always_comb begin
    if (poll) src = inj_ne ? wstd_pkg::SRC_INJECT : own_ne ? wstd_pkg::SRC_OWN :
                    steal_ok ? wstd_pkg::SRC_STOLEN : wstd_pkg::SRC_NONE;
    else      src = own_ne ? wstd_pkg::SRC_OWN : inj_ne ? wstd_pkg::SRC_INJECT :
                    steal_ok ? wstd_pkg::SRC_STOLEN : wstd_pkg::SRC_NONE;
    if (!q_word.in_range) src = wstd_pkg::SRC_NONE;
    // ring positions: sums stay below twice the depth, one subtract wraps them
    own_sum  = {1'b0, dtop[w[MW-1:0]]} + dcnt[w[MW-1:0]] - 1'b1;
    own_pos  = (own_sum >= LOCAL_DEPTH) ? LW'(own_sum - LOCAL_DEPTH) : own_sum[LW-1:0];
    push_sum = {1'b0, dtop[w[MW-1:0]]} + dcnt[w[MW-1:0]];
    push_pos = (push_sum >= LOCAL_DEPTH) ? LW'(push_sum - LOCAL_DEPTH) : push_sum[LW-1:0];
    top_v    = dtop[vic[MW-1:0]];
    inj_sum  = {1'b0, ihead} + icnt;
    ipos     = (inj_sum >= INJECT_DEPTH) ? IW'(inj_sum - INJECT_DEPTH) : inj_sum[IW-1:0];
    if (q_word.from_worker)
      sub_ok = !stopping && q_word.in_range && (dcnt[w[MW-1:0]] < LOCAL_DEPTH);
    else
      sub_ok = !stopping && (icnt < INJECT_DEPTH);
    rd_deq  = (src == wstd_pkg::SRC_OWN) || (src == wstd_pkg::SRC_STOLEN);
    rd_addr = (src == wstd_pkg::SRC_STOLEN) ? {vic, top_v} : {w, own_pos};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wstd_pkg::ST_IDLE: if (q_valid) state_next = wstd_pkg::ST_READ;
      wstd_pkg::ST_READ: state_next = wstd_pkg::ST_DONE;
      wstd_pkg::ST_DONE: state_next = wstd_pkg::ST_IDLE;
      default:           state_next = wstd_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    q_pop  = 1'b0;
    strobe = 1'b0;
    case (state)
      wstd_pkg::ST_READ: q_pop = 1'b1;
      wstd_pkg::ST_DONE: strobe = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wstd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // memories: a write for an accepted submit; both stores are read every cycle
  always_ff @(posedge clk) begin
    if (state == wstd_pkg::ST_READ && q_word.cmd == wstd_pkg::CMD_SUBMIT && sub_ok) begin
      if (q_word.from_worker) dmem[{w, push_pos}] <= q_word.task_id;
      else imem[ipos] <= q_word.task_id;
    end
    drd <= dmem[rd_addr];
    ird <= imem[ihead];
  end

  // pointer updates and result capture
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NW; i++) begin
        dtop[i]  <= '0;
        dcnt[i]  <= '0;
        tick[i]  <= '0;
        phase[i] <= '0;
      end
      ihead <= '0;
      icnt  <= '0;
    end else if (state == wstd_pkg::ST_READ) begin
      case (q_word.cmd)
        wstd_pkg::CMD_SUBMIT: begin
          if (sub_ok) begin
            if (q_word.from_worker) dcnt[w[MW-1:0]] <= dcnt[w[MW-1:0]] + 1'b1;
            else icnt <= icnt + 1'b1;
          end
        end
        wstd_pkg::CMD_FETCH: begin
          if (q_word.in_range) begin
            tick[w[MW-1:0]] <= tick[w[MW-1:0]] + 1'b1;
            if (tick[w[MW-1:0]] == '1 || phase[w[MW-1:0]] == PW'(POLL_INTERVAL - 1))
              phase[w[MW-1:0]] <= '0;
            else
              phase[w[MW-1:0]] <= phase[w[MW-1:0]] + 1'b1;
          end
          case (src)
            wstd_pkg::SRC_OWN: dcnt[w[MW-1:0]] <= dcnt[w[MW-1:0]] - 1'b1;
            wstd_pkg::SRC_INJECT: begin
              ihead <= (ihead == IW'(INJECT_DEPTH - 1)) ? '0 : ihead + 1'b1;
              icnt  <= icnt - 1'b1;
            end
            wstd_pkg::SRC_STOLEN: begin
              dtop[vic[MW-1:0]] <= (top_v == LW'(LOCAL_DEPTH - 1)) ? '0 : top_v + 1'b1;
              dcnt[vic[MW-1:0]] <= dcnt[vic[MW-1:0]] - 1'b1;
            end
            default: ;
          endcase
        end
        wstd_pkg::CMD_DISCARD: begin
          for (int i = 0; i < NW; i++) begin
            dtop[i] <= '0;
            dcnt[i] <= '0;
          end
          ihead <= '0;
          icnt  <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == wstd_pkg::ST_READ) begin
      res_acc <= (q_word.cmd == wstd_pkg::CMD_DISCARD) ||
                 (q_word.cmd == wstd_pkg::CMD_SUBMIT && sub_ok);
      res_src <= (q_word.cmd == wstd_pkg::CMD_FETCH) ? src : wstd_pkg::SRC_NONE;
      res_vic <= (q_word.cmd == wstd_pkg::CMD_FETCH && src == wstd_pkg::SRC_STOLEN) ?
                 vic : 3'd0;
      res_deq <= rd_deq;
    end
  end

  assign accepted = res_acc;
  assign source   = res_src;
  assign victim   = res_vic;
  assign found    = (res_src != wstd_pkg::SRC_NONE);
  assign task_out = (res_src == wstd_pkg::SRC_NONE) ? 16'd0 : res_deq ? drd : ird;

endmodule

// File: sv/work_stealing_task_dispatcher.sv
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher: top level
// Task dispatcher with per-worker deques, an injection FIFO and stealing.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// is on the result ports with done high during the third cycle after the
// accepting edge and must be taken then. A command passes the front queue,
// then decode with the memory access, then the result; busy drops in the
// result cycle, so the next command can be taken at the edge that ends it.
module work_stealing_task_dispatcher #(
  parameter int MAX_WORKERS   = 8,
  parameter int LOCAL_DEPTH   = 16,
  parameter int INJECT_DEPTH  = 64,
  parameter int POLL_INTERVAL = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic        from_worker,
  input  logic [2:0]  worker_id,
  input  logic [15:0] task_in,
  output logic        done,
  output logic        accepted,
  output logic        found,
  output logic [15:0] task_out,
  output logic [1:0]  source,
  output logic [2:0]  victim,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // worker ids are three bits wide, so at most eight workers are built
  localparam logic [3:0] SPAN_MAX = (MAX_WORKERS < 8) ? 4'(MAX_WORKERS) : 4'd8;

  logic [3:0] active_workers;
  logic       stopping;
  logic [3:0] span;
  logic       q_valid, q_pop, take;
  wstd_pkg::word_t q_word;

  // config registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= 4'd8;
      stopping       <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr == wstd_pkg::ADDR_ACTIVE) active_workers <= pwdata[3:0];
      if (paddr == wstd_pkg::ADDR_STOP)   stopping       <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == wstd_pkg::ADDR_ACTIVE) prdata = {28'd0, active_workers};
    else if (paddr == wstd_pkg::ADDR_STOP) prdata = {31'd0, stopping};
  end

  // clamp the worker span to 1..SPAN_MAX
  always_comb begin
    span = active_workers;
    if (span == 4'd0) span = 4'd1;
    if (span > SPAN_MAX) span = SPAN_MAX;
  end

  assign busy = q_valid;
  assign take = start && !busy;

  wstd_front u_front (
    .clk(clk), .rst(rst), .take(take), .cmd(cmd), .from_worker(from_worker),
    .worker_id(worker_id), .task_in(task_in), .span(span),
    .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
  );

  wstd_back #(
    .MAX_WORKERS(MAX_WORKERS), .LOCAL_DEPTH(LOCAL_DEPTH),
    .INJECT_DEPTH(INJECT_DEPTH), .POLL_INTERVAL(POLL_INTERVAL)
  ) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop),
    .span(span), .stopping(stopping), .strobe(done),
    .accepted(accepted), .found(found), .task_out(task_out),
    .source(source), .victim(victim)
  );

endmodule

// File: test/tb_work_stealing_task_dispatcher.sv
// ----------------------------------------------------------------------------
// tb_work_stealing_task_dispatcher: self-checking testbench
// Drives submit, fetch, discard and no-op commands with random gaps, predicts every
// result word with a behavioral copy of the deques and the injection FIFO,
// and compares each done word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_work_stealing_task_dispatcher;

  localparam int NW    = 8;
  localparam int LDEP  = 16;
  localparam int IDEP  = 64;
  localparam int POLL  = 32;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        fw;
    logic [2:0]  wid;
    logic [15:0] task_id;
  } cmd_word_t;

  typedef struct packed {
    logic        acc;
    logic        fnd;
    logic [15:0] tsk;
    logic [1:0]  src;
    logic [2:0]  vic;
  } res_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd = '0;
  logic        from_worker = 1'b0;
  logic [2:0]  worker_id = '0;
  logic [15:0] task_in = '0;
  logic        done, accepted, found;
  logic [15:0] task_out;
  logic [1:0]  source;
  logic [2:0]  victim;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  work_stealing_task_dispatcher u_top (.*);

  always #5 clk = ~clk;

  // dispatcher shadow state
  logic [15:0] dq_mem [NW][LDEP];
  int          dq_top [NW];
  int          dq_cnt [NW];
  logic [15:0] inj_mem [IDEP];
  int          inj_head, inj_cnt;
  logic [15:0] tick [NW];
  int          cfg_workers;
  bit          cfg_stop;

  cmd_word_t   pending_cmds [$];
  res_word_t   expected_res [$];
  int          errors = 0;
  int          cycles = 0;
  int          gap = 0;
  bit          hold = 1'b0;

  function automatic int span();
    if (cfg_workers < 1) return 1;
    if (cfg_workers > NW) return NW;
    return cfg_workers;
  endfunction

  // compute the result word of one command and update the shadow state
  function automatic res_word_t dispatch(cmd_word_t c);
    res_word_t r;
    int n, v, pos;
    bit poll;
    r = '0;
    n = span();
    case (c.cmd)
      wstd_pkg::CMD_SUBMIT: begin
        if (!cfg_stop) begin
          if (c.fw) begin
            if (c.wid < n && dq_cnt[c.wid] < LDEP) begin
              pos = (dq_top[c.wid] + dq_cnt[c.wid]) % LDEP;
              dq_mem[c.wid][pos] = c.task_id;
              dq_cnt[c.wid]++;
              r.acc = 1'b1;
            end
          end else if (inj_cnt < IDEP) begin
            inj_mem[(inj_head + inj_cnt) % IDEP] = c.task_id;
            inj_cnt++;
            r.acc = 1'b1;
          end
        end
      end
      wstd_pkg::CMD_FETCH: begin
        if (c.wid < n) begin
          poll = (tick[c.wid] % POLL) == 0;
          tick[c.wid] = tick[c.wid] + 16'd1;
          for (int k = 0; k < 2 && r.src == wstd_pkg::SRC_NONE; k++) begin
            if ((k == 0) == poll) begin
              if (inj_cnt > 0) begin
                r.tsk = inj_mem[inj_head];
                inj_head = (inj_head + 1) % IDEP;
                inj_cnt--;
                r.src = wstd_pkg::SRC_INJECT;
              end
            end else if (dq_cnt[c.wid] > 0) begin
              dq_cnt[c.wid]--;
              r.tsk = dq_mem[c.wid][(dq_top[c.wid] + dq_cnt[c.wid]) % LDEP];
              r.src = wstd_pkg::SRC_OWN;
            end
          end
          for (int off = 1; off < n && r.src == wstd_pkg::SRC_NONE; off++) begin
            v = (c.wid + off) % n;
            if (dq_cnt[v] > 0) begin
              r.tsk = dq_mem[v][dq_top[v]];
              dq_top[v] = (dq_top[v] + 1) % LDEP;
              dq_cnt[v]--;
              r.src = wstd_pkg::SRC_STOLEN;
              r.vic = v[2:0];
            end
          end
          r.fnd = (r.src != wstd_pkg::SRC_NONE);
        end
      end
      wstd_pkg::CMD_DISCARD: begin
        for (int i = 0; i < NW; i++) begin
          dq_top[i] = 0;
          dq_cnt[i] = 0;
        end
        inj_head = 0;
        inj_cnt = 0;
        r.acc = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, int got, int exp_val);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp_val, cycles);
    errors++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // driver: one word per handshake, random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_res.insert(expected_res.size(),
                          dispatch({cmd, from_worker, worker_id, task_in}));
      if (pending_cmds.size() > 0 && !hold && $urandom_range(0, 2) != 0) begin
        {cmd, from_worker, worker_id, task_in} <= pending_cmds[0];
        pending_cmds.delete(0);
      end else begin
        start <= 1'b0;
        gap <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 40)) :
                                             int'($urandom_range(0, 3));
      end
    end else if (!start) begin
      if (gap > 0) gap <= gap - 1;
      else if (pending_cmds.size() > 0 && !hold) begin
        {cmd, from_worker, worker_id, task_in} <= pending_cmds[0];
        pending_cmds.delete(0);
        start <= 1'b1;
      end
    end
  end

  // monitor: compare each done word with the oldest prediction
  always @(posedge clk) begin
    res_word_t e;
    if (!rst && done) begin
      if (expected_res.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        e = expected_res[0];
        expected_res.delete(0);
        if (accepted !== e.acc) report("accepted", accepted, e.acc);
        if (found !== e.fnd) report("found", found, e.fnd);
        if (task_out !== e.tsk) report("task_out", task_out, e.tsk);
        if (source !== e.src) report("source", source, e.src);
        if (victim !== e.vic) report("victim", victim, e.vic);
      end
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == wstd_pkg::ADDR_ACTIVE) cfg_workers = int'(data[3:0]);
    else cfg_stop = data[0];
  endtask

  task automatic push_cmd(logic [1:0] c, bit fw, int w, int t);
    pending_cmds.insert(pending_cmds.size(), cmd_word_t'({c, fw, w[2:0], t[15:0]}));
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start);
    while (expected_res.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // one phase of random traffic; mostly well-formed submit/fetch mixes
  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) push_cmd(wstd_pkg::CMD_SUBMIT, 1'b1, int'($urandom_range(0, 7)),
                           int'($urandom));
      else if (r < 45) push_cmd(wstd_pkg::CMD_SUBMIT, 1'b0, int'($urandom_range(0, 7)),
                                int'($urandom));
      else if (r < 94) push_cmd(wstd_pkg::CMD_FETCH, 1'($urandom_range(0, 1)),
                                int'($urandom_range(0, 7)), int'($urandom));
      else if (r < 97) push_cmd(wstd_pkg::CMD_DISCARD, 1'($urandom_range(0, 1)),
                                int'($urandom_range(0, 7)), int'($urandom));
      else push_cmd(wstd_pkg::CMD_NONE, 1'($urandom_range(0, 1)),
                    int'($urandom_range(0, 7)), int'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NW; i++) begin
      dq_top[i] = 0;
      dq_cnt[i] = 0;
      tick[i] = '0;
    end
    inj_head = 0;
    inj_cnt = 0;
    cfg_workers = 8;
    cfg_stop = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    apb_write(wstd_pkg::ADDR_ACTIVE, 32'd8);
    apb_write(wstd_pkg::ADDR_STOP, 32'd0);

    // directed: extremes, every command, poll, steal, a full deque
    push_cmd(wstd_pkg::CMD_FETCH, 1'b0, 0, 0);
    push_cmd(wstd_pkg::CMD_SUBMIT, 1'b1, 7, 16'hFFFF);
    push_cmd(wstd_pkg::CMD_SUBMIT, 1'b0, 0, 16'h0000);
    push_cmd(wstd_pkg::CMD_SUBMIT, 1'b1, 0, 16'hA5A5);
    push_cmd(wstd_pkg::CMD_FETCH, 1'b1, 0, 16'hFFFF);
    push_cmd(wstd_pkg::CMD_FETCH, 1'b0, 0, 0);
    push_cmd(wstd_pkg::CMD_FETCH, 1'b0, 3, 0);
    push_cmd(wstd_pkg::CMD_NONE, 1'b1, 7, 16'hFFFF);
    for (int i = 0; i < 17; i++) push_cmd(wstd_pkg::CMD_SUBMIT, 1'b1, 2, i * 3855);
    push_cmd(wstd_pkg::CMD_DISCARD, 1'b1, 5, 16'h5A5A);
    push_cmd(wstd_pkg::CMD_FETCH, 1'b0, 2, 0);
    drain();

    // fill the injection FIFO past full, then hand part of it out
    for (int i = 0; i < 66; i++) push_cmd(wstd_pkg::CMD_SUBMIT, 1'b0, 0, int'($urandom));
    for (int i = 0; i < 40; i++) push_cmd(wstd_pkg::CMD_FETCH, 1'b0, i % 8, 0);
    drain();

    // stopping rejects submits, fetch still works
    apb_write(wstd_pkg::ADDR_STOP, 32'd1);
    random_phase(60);
    drain();
    apb_write(wstd_pkg::ADDR_STOP, 32'd0);

    // worker span settings, extremes among them
    apb_write(wstd_pkg::ADDR_ACTIVE, 32'd1);
    random_phase(150);
    drain();
    apb_write(wstd_pkg::ADDR_ACTIVE, 32'd0);
    random_phase(100);
    drain();
    apb_write(wstd_pkg::ADDR_ACTIVE, 32'd15);
    random_phase(150);
    drain();
    apb_write(wstd_pkg::ADDR_ACTIVE, 32'd3);
    random_phase(200);
    drain();
    apb_write(wstd_pkg::ADDR_ACTIVE, 32'd8);
    random_phase(250);
    hold = 1'b1;
    while (expected_res.size() > 0 || start) @(posedge clk);
    hold = 1'b0;
    random_phase(250);
    drain();

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
